/* hdl/apmf_pkg.sv */
// ----------------------------------------------------------------------------
// apmf_pkg: shared types and constants for the augmenting path max flow block
// Holds default sizes, field widths, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package apmf_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int CAP_BITS_DEF  = 8;
    localparam int CFG_BITS      = 5;
    localparam int NODE_BITS     = 4;
    localparam int FLOW_BITS     = 12;
    localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_SOURCE     = 2'd1;
    localparam logic [1:0] REG_SINK       = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_RUN   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_SELECT,
        ST_RELAX_RD,
        ST_RELAX,
        ST_BOT_RD,
        ST_BOT,
        ST_UPD_RD,
        ST_UPD_FWD,
        ST_UPD_BACK,
        ST_UPD_WR,
        ST_DONE
    } apmf_state_t;

endpackage

/* hdl/apmf_ram.sv */
// ----------------------------------------------------------------------------
// apmf_ram: generic single port synchronous RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module apmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Memory array with a registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hdl/augmenting_path_max_flow.sv */
// ----------------------------------------------------------------------------
// augmenting_path_max_flow: maximum flow over a residual capacity matrix
// Loads capacities into a residual memory, then runs shortest augmenting paths.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) carries requests. A request with
// req_type 0 writes one capacity entry at its transfer edge and gives no
// result; writes can follow each other every cycle while the block is idle.
// A request with req_type 1 runs the flow computation and gives one max_flow
// transfer on the output channel (out_valid/out_stall).
// A run's duration depends on the data: each round does a search of up to N
// selections, each a scan of the N node registers plus N memory reads of one
// row, then walks back along the path twice, once for the bottleneck and once
// for the update. The single port residual memory serializes these reads and
// writes. A run with bad endpoints goes to the done state at the request
// transfer and then shows its result.
// After reset a clearing pass over the whole memory (256 entries for 16 nodes)
// zeroes it; no request is taken during it, configuration writes are taken at
// any time. The result sits in an output register until it is transferred; a
// stalled receiver holds the block, and the next request is taken after the
// result transfer.
// ----------------------------------------------------------------------------
module augmenting_path_max_flow
    import apmf_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int CAP_BITS  = CAP_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [apmf_pkg::CFG_BITS-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [apmf_pkg::NODE_BITS-1:0] row_node,
    input  logic [apmf_pkg::NODE_BITS-1:0] col_node,
    input  logic [7:0]                    capacity,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [apmf_pkg::FLOW_BITS-1:0] max_flow
);

    localparam int NB = $clog2(MAX_NODES);
    localparam int AB = 2 * NB;
    localparam int DB = CAP_BITS + NB + 1;
    localparam int CB = NB + 1;
    localparam int SB = ((CAP_BITS > FLOW_BITS) ? CAP_BITS : FLOW_BITS) + 1;
    localparam int RAM_DEPTH = 1 << AB;
    localparam logic [CAP_BITS-1:0] CAP_MAX = '1;

    // Configuration registers.
    logic [4:0] node_count_reg;
    logic [3:0] source_reg, sink_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 5'd16;
            source_reg     <= 4'd0;
            sink_reg       <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NODE_COUNT: node_count_reg <= cfg_data;
                REG_SOURCE:     source_reg     <= cfg_data[3:0];
                REG_SINK:       sink_reg       <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // Clamped node count and the endpoints in the node index space.
    logic [CB-1:0] n_live;
    logic [NB-1:0] src_idx, snk_idx;
    always_comb
    begin
        if (node_count_reg < 5'd2)
            n_live = CB'(2);
        else if (32'(node_count_reg) > MAX_NODES)
            n_live = CB'(MAX_NODES);
        else
            n_live = CB'(node_count_reg);
    end
    assign src_idx = NB'(source_reg);
    assign snk_idx = NB'(sink_reg);

    // Residual memory.
    logic                ram_we;
    logic [AB-1:0]       ram_addr;
    logic [CAP_BITS-1:0] ram_wdata, ram_rdata;

    apmf_ram #(.WIDTH(CAP_BITS), .DEPTH(RAM_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Per node search registers.
    logic [DB-1:0] dist_reg [MAX_NODES];
    logic [NB-1:0] par_reg  [MAX_NODES];
    logic [MAX_NODES-1:0] vis_reg, rch_reg;

    apmf_state_t   state_reg, state_next;
    logic [AB:0]   clr_reg;
    logic          clr_busy;
    logic [NB-1:0] u_reg, u_next;
    logic [CB-1:0] j_reg, j_next;
    logic [NB-1:0] best_reg, best_next;
    logic          found_reg, found_next;
    logic [NB-1:0] v_reg, v_next;
    logic [CB-1:0] steps_reg, steps_next;
    logic [CAP_BITS-1:0] bott_reg, bott_next;
    logic [CAP_BITS-1:0] fwd_reg;
    logic [FLOW_BITS-1:0] flow_reg, flow_next;
    logic          out_valid_reg;

    assign clr_busy  = !clr_reg[AB];
    assign in_stall  = clr_busy || (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign max_flow  = flow_reg;

    logic [DB-1:0] cand;
    logic [NB-1:0] j_idx, p_idx;
    logic [CAP_BITS:0] back_sum;
    logic [SB-1:0] flow_sum;
    logic accept, run_ok, relax_hit, walk_end;
    assign accept   = in_valid && !in_stall;
    assign j_idx    = j_reg[NB-1:0];
    assign p_idx    = par_reg[v_reg];
    assign cand     = dist_reg[u_reg] + DB'(ram_rdata);
    assign back_sum = {1'b0, ram_rdata} + {1'b0, bott_reg};
    assign flow_sum = SB'(flow_reg) + SB'(bott_reg);
    assign run_ok   = (32'(source_reg) < 32'(n_live)) && (32'(sink_reg) < 32'(n_live)) &&
                      (source_reg != sink_reg);
    assign relax_hit = (state_reg == ST_RELAX) && (ram_rdata != '0) &&
                       (!rch_reg[j_idx] || cand <= dist_reg[j_idx]);
    assign walk_end = (v_reg == src_idx) || (steps_reg == n_live);

    // Sequencer next state and memory access.
    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        j_next     = j_reg;
        best_next  = best_reg;
        found_next = found_reg;
        v_next     = v_reg;
        steps_next = steps_reg;
        bott_next  = bott_reg;
        flow_next  = flow_reg;
        ram_we     = 1'b0;
        ram_addr   = '0;
        ram_wdata  = '0;
        if (clr_busy)
        begin
            ram_we   = 1'b1;
            ram_addr = clr_reg[AB-1:0];
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type == REQ_WRITE)
                begin
                    if (32'(row_node) < MAX_NODES && 32'(col_node) < MAX_NODES)
                    begin
                        ram_we    = 1'b1;
                        ram_addr  = {NB'(row_node), NB'(col_node)};
                        ram_wdata = (32'(capacity) > 32'(CAP_MAX)) ? CAP_MAX
                                                                    : CAP_BITS'(capacity);
                    end
                end
                else if (accept)
                begin
                    flow_next  = '0;
                    state_next = run_ok ? ST_INIT : ST_DONE;
                end
            end
            ST_INIT:
            begin
                j_next     = '0;
                found_next = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // One node per cycle; a strict compare keeps the lowest index on ties.
                if (rch_reg[j_idx] && !vis_reg[j_idx] &&
                    (!found_reg || dist_reg[j_idx] < dist_reg[best_reg]))
                begin
                    best_next  = j_idx;
                    found_next = 1'b1;
                end
                if (j_reg + CB'(1) == n_live)
                    state_next = ST_SELECT;
                else
                    j_next = j_reg + CB'(1);
            end
            ST_SELECT:
            begin
                if (found_reg)
                begin
                    u_next     = best_reg;
                    j_next     = '0;
                    state_next = ST_RELAX_RD;
                end
                else if (rch_reg[snk_idx])
                begin
                    v_next     = snk_idx;
                    steps_next = '0;
                    bott_next  = CAP_MAX;
                    state_next = ST_BOT_RD;
                end
                else
                    state_next = ST_DONE;
            end
            ST_RELAX_RD:
            begin
                ram_addr   = {u_reg, j_idx};
                state_next = ST_RELAX;
            end
            ST_RELAX:
            begin
                if (j_reg + CB'(1) == n_live)
                begin
                    j_next     = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    j_next     = j_reg + CB'(1);
                    state_next = ST_RELAX_RD;
                end
            end
            ST_BOT_RD:
            begin
                if (walk_end)
                begin
                    if (bott_reg == '0)
                        state_next = ST_DONE;
                    else
                    begin
                        v_next     = snk_idx;
                        steps_next = '0;
                        state_next = ST_UPD_RD;
                    end
                end
                else
                begin
                    ram_addr   = {p_idx, v_reg};
                    state_next = ST_BOT;
                end
            end
            ST_BOT:
            begin
                if (ram_rdata < bott_reg)
                    bott_next = ram_rdata;
                v_next     = p_idx;
                steps_next = steps_reg + CB'(1);
                state_next = ST_BOT_RD;
            end
            ST_UPD_RD:
            begin
                if (walk_end)
                begin
                    if (flow_sum > SB'(FLOW_MAX))
                        flow_next = FLOW_MAX;
                    else
                        flow_next = FLOW_BITS'(flow_sum);
                    state_next = ST_INIT;
                end
                else
                begin
                    ram_addr   = {p_idx, v_reg};
                    state_next = ST_UPD_FWD;
                end
            end
            ST_UPD_FWD:
            begin
                // Forward entry is on the read port; fetch the backward entry.
                ram_addr   = {v_reg, p_idx};
                state_next = ST_UPD_BACK;
            end
            ST_UPD_BACK:
            begin
                // Backward entry grows by the bottleneck and saturates.
                ram_we     = 1'b1;
                ram_addr   = {v_reg, p_idx};
                ram_wdata  = back_sum[CAP_BITS] ? CAP_MAX : back_sum[CAP_BITS-1:0];
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                // Forward entry shrinks by the bottleneck, then step to the parent.
                ram_we     = 1'b1;
                ram_addr   = {p_idx, v_reg};
                ram_wdata  = fwd_reg;
                v_next     = p_idx;
                steps_next = steps_reg + CB'(1);
                state_next = ST_UPD_RD;
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer and search flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            flow_reg      <= '0;
            vis_reg       <= '0;
            rch_reg       <= '0;
        end
        else
        begin
            if (clr_busy)
                clr_reg <= clr_reg + (AB+1)'(1);
            state_reg <= state_next;
            flow_reg  <= flow_next;
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_INIT)
            begin
                vis_reg <= '0;
                rch_reg <= MAX_NODES'(1) << src_idx;
            end
            if (state_reg == ST_SELECT && found_reg)
                vis_reg[best_reg] <= 1'b1;
            if (relax_hit)
                rch_reg[j_idx] <= 1'b1;
        end
    end

    // Payload registers of the search and path walk.
    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        j_reg     <= j_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        v_reg     <= v_next;
        steps_reg <= steps_next;
        bott_reg  <= bott_next;
        if (state_reg == ST_UPD_FWD)
            fwd_reg <= ram_rdata - bott_reg;
        if (state_reg == ST_INIT)
        begin
            dist_reg[src_idx] <= '0;
            par_reg[src_idx]  <= src_idx;
        end
        if (relax_hit)
        begin
            dist_reg[j_idx] <= cand;
            par_reg[j_idx]  <= u_reg;
        end
    end

endmodule
